/* rtl/linked_list_union_find_top_macros.svh */
// assertion macros of the port level checker file
`ifndef LINKED_LIST_UNION_FIND_TOP_MACROS_SVH
`define LINKED_LIST_UNION_FIND_TOP_MACROS_SVH

// same-cycle implication under clock and active-low reset
`define LLUF_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("linked list union find check failed");

// next-cycle implication under clock and active-low reset
`define LLUF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("linked list union find check failed");

`endif

/* rtl/lluf_pkg.sv */
// types and codes of the linked list union find block
package lluf_pkg;

  typedef logic [7:0] key_t;
  typedef logic [8:0] size_t;

  typedef enum logic [1:0] {
    MODE_MAKE  = 2'd0,
    MODE_FIND  = 2'd1,
    MODE_UNION = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ABSENT  = 2'd1,
    ST_PRESENT = 2'd2,
    ST_SAME    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FREP,
    S_FSIZE,
    S_UREPA,
    S_UREPB,
    S_ROOTA,
    S_ROOTB,
    S_LINK,
    S_WALK
  } state_e;

  // per-member word: representative and next member
  typedef struct packed {
    key_t rep;
    key_t nxt;
  } node_t;

  // per-representative word: list tail and member count
  typedef struct packed {
    key_t  tail;
    size_t sz;
  } root_t;

endpackage

/* rtl/linked_list_union_find_top.sv */
// linked list disjoint set store with weighted union
//
// command channel: a beat (mode_i, key_a_i, key_b_i) is taken at a rising edge
// with start high and busy low. modes: make_set, find, union, and a no-op code.
// result channel: result_valid_o strobes for one cycle with representative_o,
// set_size_o and status_o; the receiver cannot stall, so a result is never held.
// steps from the accepting edge to the strobe:
//   make_set, no-op, and any request with an absent key: busy stays low
//   find: node read, then root read
//   union: node reads, root reads, the survivor's tail link, then a relabel walk
//   of one member per cycle over n members through the node memory, n the size of
//   the appended (smaller) set, at most ENTRIES/2; one set: no link or walk
// one request at a time: busy stays high until the result strobes; the next beat
// can be taken in the strobe cycle.
// state: a node memory {rep, next} and a root memory {tail, size}, both with one
// write and one registered read port, plus a presence map in flip-flops.
// reset clears the presence map at once; no clearing pass is needed, the link
// tables are only read at keys that were created.
module linked_list_union_find_top #(
  parameter int unsigned ENTRIES = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  logic [1:0]    mode_i,
  input  lluf_pkg::key_t key_a_i,
  input  lluf_pkg::key_t key_b_i,
  output logic          result_valid_o,
  output lluf_pkg::key_t representative_o,
  output lluf_pkg::size_t set_size_o,
  output logic [1:0]    status_o
);

  import lluf_pkg::*;

  localparam int unsigned AW  = $clog2(ENTRIES);
  // only keys below 256 exist, so the presence map needs no more bits
  localparam int unsigned PW  = (ENTRIES < 256) ? ENTRIES : 256;
  localparam int unsigned PAW = $clog2(PW);

  // a key that the memories can hold
  function automatic logic in_range(key_t k);
    return 32'(k) < ENTRIES;
  endfunction

  state_e state_q, state_d;

  logic [PW-1:0] present_q;
  logic          set_present;

  // working registers of a request
  key_t  kb_q, kb_d;
  key_t  ra_q, ra_d;
  key_t  rb_q, rb_d;
  key_t  tail_a_q, tail_a_d;
  size_t size_a_q, size_a_d;
  key_t  surv_q, surv_d;
  key_t  app_q, app_d;
  key_t  tail_app_q, tail_app_d;
  size_t sum_q, sum_d;
  size_t cnt_q, cnt_d;
  key_t  cur_q, cur_d;

  // result register
  logic    res_valid_q, res_valid_d;
  key_t    res_rep_q, res_rep_d;
  size_t   res_size_q, res_size_d;
  status_e res_status_q, res_status_d;

  // memory ports
  logic          n_we, r_we;
  logic [AW-1:0] n_waddr, n_raddr, r_waddr, r_raddr;
  node_t         n_wdata, n_rdata;
  root_t         r_wdata, r_rdata;

  logic a_in, a_has, b_has, b_smaller;

  assign a_in      = in_range(key_a_i);
  assign a_has     = a_in && present_q[key_a_i[PAW-1:0]];
  assign b_has     = in_range(key_b_i) && present_q[key_b_i[PAW-1:0]];
  // on equal sizes the set of the second key survives
  assign b_smaller = r_rdata.sz < size_a_q;

  lluf_ram #(
    .WIDTH($bits(node_t)),
    .DEPTH(ENTRIES)
  ) u_node_ram (
    .clk_i  (clk_i),
    .we_i   (n_we),
    .waddr_i(n_waddr),
    .wdata_i(n_wdata),
    .raddr_i(n_raddr),
    .rdata_o(n_rdata)
  );

  lluf_ram #(
    .WIDTH($bits(root_t)),
    .DEPTH(ENTRIES)
  ) u_root_ram (
    .clk_i  (clk_i),
    .we_i   (r_we),
    .waddr_i(r_waddr),
    .wdata_i(r_wdata),
    .raddr_i(r_raddr),
    .rdata_o(r_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      present_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      if (set_present) begin
        present_q[key_a_i[PAW-1:0]] <= 1'b1;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    kb_q         <= kb_d;
    ra_q         <= ra_d;
    rb_q         <= rb_d;
    tail_a_q     <= tail_a_d;
    size_a_q     <= size_a_d;
    surv_q       <= surv_d;
    app_q        <= app_d;
    tail_app_q   <= tail_app_d;
    sum_q        <= sum_d;
    cnt_q        <= cnt_d;
    cur_q        <= cur_d;
    res_rep_q    <= res_rep_d;
    res_size_q   <= res_size_d;
    res_status_q <= res_status_d;
  end

  always_comb begin
    state_d      = state_q;
    set_present  = 1'b0;
    kb_d         = kb_q;
    ra_d         = ra_q;
    rb_d         = rb_q;
    tail_a_d     = tail_a_q;
    size_a_d     = size_a_q;
    surv_d       = surv_q;
    app_d        = app_q;
    tail_app_d   = tail_app_q;
    sum_d        = sum_q;
    cnt_d        = cnt_q;
    cur_d        = cur_q;
    res_valid_d  = 1'b0;
    res_rep_d    = res_rep_q;
    res_size_d   = res_size_q;
    res_status_d = res_status_q;
    n_we         = 1'b0;
    n_waddr      = AW'(cur_q);
    n_wdata      = '{rep: surv_q, nxt: n_rdata.nxt};
    n_raddr      = AW'(key_a_i);
    r_we         = 1'b0;
    r_waddr      = AW'(surv_q);
    r_wdata      = '{tail: tail_app_q, sz: sum_q};
    r_raddr      = AW'(ra_q);

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (mode_e'(mode_i))
            MODE_MAKE: begin
              res_valid_d = 1'b1;
              if (!a_in) begin
                res_rep_d    = '0;
                res_size_d   = '0;
                res_status_d = ST_ABSENT;
              end else if (present_q[key_a_i[PAW-1:0]]) begin
                res_rep_d    = '0;
                res_size_d   = '0;
                res_status_d = ST_PRESENT;
              end else begin
                // singleton: the key is its own rep, next and tail
                set_present  = 1'b1;
                n_we         = 1'b1;
                n_waddr      = AW'(key_a_i);
                n_wdata      = '{rep: key_a_i, nxt: key_a_i};
                r_we         = 1'b1;
                r_waddr      = AW'(key_a_i);
                r_wdata      = '{tail: key_a_i, sz: size_t'(1)};
                res_rep_d    = key_a_i;
                res_size_d   = size_t'(1);
                res_status_d = ST_OK;
              end
            end
            MODE_FIND: begin
              if (a_has) begin
                state_d = S_FREP;
              end else begin
                res_valid_d  = 1'b1;
                res_rep_d    = '0;
                res_size_d   = '0;
                res_status_d = ST_ABSENT;
              end
            end
            MODE_UNION: begin
              if (a_has && b_has) begin
                kb_d    = key_b_i;
                state_d = S_UREPA;
              end else begin
                res_valid_d  = 1'b1;
                res_rep_d    = '0;
                res_size_d   = '0;
                res_status_d = ST_ABSENT;
              end
            end
            MODE_NONE: begin
              res_valid_d  = 1'b1;
              res_rep_d    = '0;
              res_size_d   = '0;
              res_status_d = ST_OK;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_FREP: begin
        ra_d    = n_rdata.rep;
        r_raddr = AW'(n_rdata.rep);
        state_d = S_FSIZE;
      end
      S_FSIZE: begin
        res_valid_d  = 1'b1;
        res_rep_d    = ra_q;
        res_size_d   = r_rdata.sz;
        res_status_d = ST_OK;
        state_d      = S_IDLE;
      end
      S_UREPA: begin
        ra_d    = n_rdata.rep;
        n_raddr = AW'(kb_q);
        state_d = S_UREPB;
      end
      S_UREPB: begin
        rb_d    = n_rdata.rep;
        r_raddr = AW'(ra_q);
        state_d = S_ROOTA;
      end
      S_ROOTA: begin
        tail_a_d = r_rdata.tail;
        size_a_d = r_rdata.sz;
        if (ra_q == rb_q) begin
          res_valid_d  = 1'b1;
          res_rep_d    = ra_q;
          res_size_d   = r_rdata.sz;
          res_status_d = ST_SAME;
          state_d      = S_IDLE;
        end else begin
          r_raddr = AW'(rb_q);
          state_d = S_ROOTB;
        end
      end
      S_ROOTB: begin
        // pick survivor, then fetch the survivor's tail node to relink it
        surv_d     = b_smaller ? ra_q : rb_q;
        app_d      = b_smaller ? rb_q : ra_q;
        tail_app_d = b_smaller ? r_rdata.tail : tail_a_q;
        cnt_d      = b_smaller ? r_rdata.sz : size_a_q;
        cur_d      = b_smaller ? tail_a_q : r_rdata.tail;
        sum_d      = size_a_q + r_rdata.sz;
        n_raddr    = AW'(b_smaller ? tail_a_q : r_rdata.tail);
        state_d    = S_LINK;
      end
      S_LINK: begin
        // survivor tail now points at the appended head; keep its rep
        n_we    = 1'b1;
        n_waddr = AW'(cur_q);
        n_wdata = '{rep: n_rdata.rep, nxt: app_q};
        n_raddr = AW'(app_q);
        cur_d   = app_q;
        state_d = S_WALK;
      end
      S_WALK: begin
        // relabel one appended member and fetch the next one
        n_we    = 1'b1;
        n_waddr = AW'(cur_q);
        n_wdata = '{rep: surv_q, nxt: n_rdata.nxt};
        n_raddr = AW'(n_rdata.nxt);
        cur_d   = n_rdata.nxt;
        cnt_d   = cnt_q - size_t'(1);
        if (cnt_q == size_t'(1)) begin
          r_we         = 1'b1;
          r_waddr      = AW'(surv_q);
          r_wdata      = '{tail: tail_app_q, sz: sum_q};
          res_valid_d  = 1'b1;
          res_rep_d    = surv_q;
          res_size_d   = sum_q;
          res_status_d = ST_OK;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy             = (state_q != S_IDLE);
  assign result_valid_o   = res_valid_q;
  assign representative_o = res_rep_q;
  assign set_size_o       = res_size_q;
  assign status_o         = res_status_q;

endmodule

/* rtl/lluf_ram.sv */
// generic simple dual port ram with registered read
module lluf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/lluf_checker.sv */
// port level checks of the linked list union find block, with bind
`include "linked_list_union_find_top_macros.svh"

module lluf_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic [1:0]     mode_i,
  input lluf_pkg::key_t key_a_i,
  input logic           result_valid_o,
  input lluf_pkg::key_t representative_o,
  input lluf_pkg::size_t set_size_o,
  input logic [1:0]     status_o
);

  import lluf_pkg::*;

  logic take;
  assign take = start && !busy;

  // results only come out once the sequencer is back at rest
  `LLUF_ASSERT_IMPL(a_res_idle, clk_i, rst_ni, result_valid_o, !busy)

  // error results carry no set
  `LLUF_ASSERT_IMPL(a_err_zero, clk_i, rst_ni,
    result_valid_o && (status_o == ST_ABSENT || status_o == ST_PRESENT),
    representative_o == '0 && set_size_o == '0)

  // make_set answers in the next cycle, a new singleton names its key
  `LLUF_ASSERT_NEXT(a_make, clk_i, rst_ni, take && mode_i == MODE_MAKE,
    result_valid_o && (status_o != ST_OK ||
    (representative_o == $past(key_a_i) && set_size_o == 9'd1)))

  // the no-op code answers straight from idle with an empty ok result
  `LLUF_ASSERT_NEXT(a_noop, clk_i, rst_ni, take && mode_i == MODE_NONE,
    result_valid_o && status_o == ST_OK && representative_o == '0 && set_size_o == '0)

endmodule

bind linked_list_union_find_top lluf_checker u_lluf_checker (.*);

/* tb/lluf_checker.sv */
// scoreboard for the linked list union find block: predicts each answer and compares
module lluf_scoreboard (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            busy_i,
  input  logic [1:0]      mode_i,
  input  lluf_pkg::key_t  key_a_i,
  input  lluf_pkg::key_t  key_b_i,
  input  logic            res_valid_i,
  input  lluf_pkg::key_t  rep_i,
  input  lluf_pkg::size_t size_i,
  input  logic [1:0]      status_i,
  output int unsigned     pending_o,
  output int unsigned     errors_o
);

  import lluf_pkg::*;

  typedef struct packed {
    key_t    rep;
    size_t   members;
    status_e status;
  } answer_t;

  // shadow of the set store
  bit    key_live [256];
  key_t  owner_of [256];
  key_t  link_of  [256];
  key_t  last_of  [256];
  size_t count_of [256];

  answer_t set_answers_q [$];

  function automatic answer_t disjoint_set_step(mode_e op, key_t ka, key_t kb);
    answer_t ans;
    key_t    ra;
    key_t    rb;
    key_t    keep;
    key_t    moved;
    key_t    walk;
    ans = '{rep: '0, members: '0, status: ST_OK};
    case (op)
      MODE_MAKE: begin
        if (key_live[ka]) begin
          ans.status = ST_PRESENT;
        end else begin
          key_live[ka] = 1'b1;
          owner_of[ka] = ka;
          link_of[ka]  = ka;
          last_of[ka]  = ka;
          count_of[ka] = 9'd1;
          ans = '{rep: ka, members: 9'd1, status: ST_OK};
        end
      end
      MODE_FIND: begin
        if (!key_live[ka]) begin
          ans.status = ST_ABSENT;
        end else begin
          ans.rep     = owner_of[ka];
          ans.members = count_of[owner_of[ka]];
        end
      end
      MODE_UNION: begin
        if (!key_live[ka] || !key_live[kb]) begin
          ans.status = ST_ABSENT;
        end else begin
          ra = owner_of[ka];
          rb = owner_of[kb];
          if (ra == rb) begin
            ans = '{rep: ra, members: count_of[ra], status: ST_SAME};
          end else begin
            // smaller list goes behind the larger, ties keep the second key's set
            if (count_of[rb] < count_of[ra]) begin
              keep  = ra;
              moved = rb;
            end else begin
              keep  = rb;
              moved = ra;
            end
            link_of[last_of[keep]] = moved;
            walk = moved;
            for (int i = 0; i < int'(count_of[moved]); i++) begin
              owner_of[walk] = keep;
              walk = link_of[walk];
            end
            last_of[keep]  = last_of[moved];
            count_of[keep] = count_of[keep] + count_of[moved];
            ans = '{rep: keep, members: count_of[keep], status: ST_OK};
          end
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      foreach (key_live[k]) key_live[k] = 1'b0;
      set_answers_q.delete();
      pending_o = 0;
      errors_o  = 0;
    end else begin
      // answers first: a beat taken at this edge cannot answer at the same edge
      if (res_valid_i) begin
        if (set_answers_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10)
            $display("%0t: unexpected answer rep=%0d size=%0d status=%0d",
                     $realtime, rep_i, size_i, status_i);
        end else begin
          want = set_answers_q.pop_front();
          if (want.rep !== rep_i || want.members !== size_i || want.status !== status_i) begin
            errors_o++;
            if (errors_o <= 10)
              $display("%0t: mismatch rep %0d/%0d size %0d/%0d status %0d/%0d (exp/act)",
                       $realtime, want.rep, rep_i, want.members, size_i,
                       want.status, status_i);
          end
        end
      end
      if (start_i && !busy_i)
        set_answers_q.push_back(disjoint_set_step(mode_e'(mode_i), key_a_i, key_b_i));
      pending_o = set_answers_q.size();
    end
  end

endmodule

/* tb/tb.sv */
// stimulus and verdict for the linked list union find block
module tb;
  import lluf_pkg::*;

  // longest correct quiet stretch is a 128-member relabel walk plus a sender gap
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PHASE_ITEMS    = 400;
  localparam int unsigned TAIL_CYCLES    = 200;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        start   = 1'b0;
  logic        busy;
  logic [1:0]  mode_i  = MODE_NONE;
  key_t        key_a_i = '0;
  key_t        key_b_i = '0;
  logic        result_valid_o;
  key_t        representative_o;
  size_t       set_size_o;
  logic [1:0]  status_o;

  int unsigned pending;
  int unsigned errors;

  // percent of cycles in which the sender holds back a beat
  int unsigned idle_pct = 0;
  // keys the stimulus has already tried to create; a make_set always leaves its key present
  bit made_keys [256];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  linked_list_union_find_top u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .mode_i           (mode_i),
    .key_a_i          (key_a_i),
    .key_b_i          (key_b_i),
    .result_valid_o   (result_valid_o),
    .representative_o (representative_o),
    .set_size_o       (set_size_o),
    .status_o         (status_o)
  );

  lluf_scoreboard u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .mode_i      (mode_i),
    .key_a_i     (key_a_i),
    .key_b_i     (key_b_i),
    .res_valid_i (result_valid_o),
    .rep_i       (representative_o),
    .size_i      (set_size_o),
    .status_i    (status_o),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  // one command beat, entered and left at a falling edge; start stays high on return
  // so that the next call (or settle) makes the only assignment of that step
  task automatic issue(input mode_e op, input key_t ka, input key_t kb);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start   <= 1'b1;
    mode_i  <= op;
    key_a_i <= ka;
    key_b_i <= kb;
    // busy read right after the edge is the value the block saw at that edge
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    if (op == MODE_MAKE) made_keys[ka] = 1'b1;
  endtask

  // hold off until the block has answered everything taken so far
  task automatic settle();
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  // mostly keys that already exist, so finds and unions get past the absent check
  function automatic key_t pick_key(int unsigned lo, int unsigned hi);
    key_t k;
    k = key_t'($urandom_range(hi, lo));
    for (int i = 0; i < 12; i++) begin
      if (made_keys[k]) return k;
      k = key_t'($urandom_range(hi, lo));
    end
    return k;
  endfunction

  task automatic random_item(input int unsigned lo, input int unsigned hi);
    int unsigned dice;
    dice = $urandom_range(99);
    if (dice < 26)
      issue(MODE_MAKE, key_t'($urandom_range(hi, lo)), key_t'($urandom));
    else if (dice < 46)
      issue(MODE_FIND, pick_key(lo, hi), key_t'($urandom));
    else if (dice < 90)
      issue(MODE_UNION, pick_key(lo, hi), pick_key(lo, hi));
    else if (dice < 94)
      issue(MODE_NONE, key_t'($urandom), key_t'($urandom));
    else
      // noise: any code with any keys
      issue(mode_e'($urandom_range(3)), key_t'($urandom), key_t'($urandom));
  endtask

  initial begin : stimulus
    int unsigned lo;
    int unsigned hi;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty store, extremes of the key range, every error path
    issue(MODE_FIND,  8'd0,   8'd255);   // absent key on find
    issue(MODE_FIND,  8'd255, 8'd0);
    issue(MODE_UNION, 8'd0,   8'd255);   // both keys absent
    issue(MODE_NONE,  8'd255, 8'd255);   // unused code
    issue(MODE_MAKE,  8'd0,   8'd255);
    issue(MODE_MAKE,  8'd255, 8'd0);
    issue(MODE_MAKE,  8'd0,   8'd0);     // key already present
    issue(MODE_FIND,  8'd0,   8'd0);
    issue(MODE_UNION, 8'd0,   8'd255);   // equal sizes, second key's set survives
    issue(MODE_UNION, 8'd255, 8'd0);     // same set
    issue(MODE_UNION, 8'd0,   8'd0);     // both keys equal
    issue(MODE_UNION, 8'd0,   8'd2);     // second key absent
    issue(MODE_UNION, 8'd2,   8'd0);     // first key absent
    issue(MODE_MAKE,  8'd1,   8'd170);
    issue(MODE_UNION, 8'd1,   8'd0);     // singleton appended to a larger set
    issue(MODE_MAKE,  8'd170, 8'd85);
    issue(MODE_MAKE,  8'd85,  8'd170);
    issue(MODE_UNION, 8'd85,  8'd170);
    issue(MODE_UNION, 8'd170, 8'd1);     // two-member list relabeled
    issue(MODE_FIND,  8'd85,  8'd0);
    issue(MODE_FIND,  8'd170, 8'd255);
    issue(MODE_NONE,  8'd0,   8'd0);
    settle();

    // random: low half, then high half grow their own sets, then both are merged
    // so that the last phase appends lists of up to half the keys
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 37 : (ph == 1) ? 49 : 0;
      lo = (ph == 1) ? 128 : 0;
      hi = (ph == 0) ? 127 : 255;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_item(lo, hi);
        if ($urandom_range(99) == 0) settle();
      end
      settle();
    end

    // late answers would still be caught by the checker
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (errors == 0 && pending == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

  // watchdog: too many cycles without a beat taken or an answer given
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (start && !busy) || result_valid_o)
        quiet = 0;
      else
        quiet++;
    end
    $display("tb NOT OK");
    $finish;
  end

endmodule
